// ===== hdl/skf_pkg.sv =====
package skf_pkg;

  localparam int unsigned CovW  = 31;
  localparam int unsigned EstW  = 32;
  localparam int unsigned GainW = 17;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivCntW = 5;

  localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_ESTIMATE   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_COVARIANCE = 2'd3;

  localparam logic [CovW-1:0]  RST_PROCESS_NOISE      = 31'd6554;
  localparam logic [CovW-1:0]  RST_MEASUREMENT_NOISE  = 31'd65536;
  localparam logic [EstW-1:0]  RST_INITIAL_ESTIMATE   = 32'd0;
  localparam logic [CovW-1:0]  RST_INITIAL_COVARIANCE = 31'd65536;

  // gain of 1.0 in q1.16
  localparam logic [GainW-1:0] GAIN_ONE = 17'd65536;
  localparam logic [DivCntW-1:0] DIV_LAST_BIT = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MULX,
    ST_UPDX,
    ST_MULP,
    ST_UPDP,
    ST_FINISH
  } skf_state_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic div_step;
    logic mul_x;
    logic upd_x;
    logic mul_p;
    logic upd_p;
    logic load_out;
  } skf_cmd_t;

  typedef struct packed {
    logic bad;
    logic sat;
    logic div_done;
    logic out_free;
  } skf_status_t;

endpackage

// ===== hdl/skf_ctrl.sv =====
module skf_ctrl import skf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  skf_status_t status,
  output skf_cmd_t    cmd
);

  skf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = status.bad ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_nxt = ST_MULX;
      end
      ST_MULX: state_nxt = ST_UPDX;
      ST_UPDX: begin
        state_nxt = status.sat ? ST_FINISH : ST_MULP;
      end
      ST_MULP: state_nxt = ST_UPDP;
      ST_UPDP: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.accept = in_valid;
      end
      ST_CHECK:  cmd.check = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_MULX:   cmd.mul_x = 1'b1;
      ST_UPDX:   cmd.upd_x = 1'b1;
      ST_MULP:   cmd.mul_p = 1'b1;
      ST_UPDP:   cmd.upd_p = 1'b1;
      ST_FINISH: cmd.load_out = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hdl/skf_dp.sv =====
module skf_dp import skf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CfgW-1:0]         cfg_wdata,
  input  logic signed [EstW-1:0]  in_measurement,
  input  logic                    in_restart,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [EstW-1:0]  out_estimate,
  output logic [GainW-1:0]        out_gain,
  output logic                    out_error,
  input  skf_cmd_t                cmd,
  output skf_status_t             status
);

  logic [CovW-1:0]  q_r, r_r, init_cov_r;
  logic [EstW-1:0]  init_est_r;

  logic [EstW-1:0]  x_r;
  logic [EstW-1:0]  p_r;
  logic             halted_r;
  logic [EstW-1:0]  z_r;
  logic             err_r;

  logic [EstW-1:0]  p1_r;
  logic [EstW-1:0]  den_r;
  logic [EstW:0]    rem_r;
  logic [GainW-1:0] k_r;
  logic [DivCntW-1:0] cnt_r;
  logic signed [51:0] prod_r;

  logic             out_valid_r;
  logic [EstW-1:0]  out_est_r;
  logic [GainW-1:0] out_gain_r;
  logic             out_err_r;

  // covariance plus process noise, then plus measurement noise
  logic [EstW-1:0]  p1_nxt;
  logic [EstW:0]    den_nxt;
  logic             bad;
  logic             rem_ge;
  logic [EstW:0]    rem_diff;
  logic [EstW:0]    diff;
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] prod_nxt;
  logic signed [51:0] prod_rnd;
  logic [33:0]      x_nxt;
  logic             sat;
  logic [GainW-1:0] one_minus_k;

  always_comb begin
    p1_nxt  = {1'b0, p_r[CovW-1:0]} + {1'b0, q_r};
    den_nxt = {1'b0, p1_nxt} + {2'b0, r_r};
    bad     = halted_r | p1_nxt[EstW-1] | (den_nxt == '0);

    rem_ge   = rem_r >= {1'b0, den_r};
    rem_diff = rem_ge ? (rem_r - {1'b0, den_r}) : rem_r;

    diff        = {z_r[EstW-1], z_r} - {x_r[EstW-1], x_r};
    one_minus_k = GAIN_ONE - k_r;
    if (cmd.mul_p) begin
      mul_a = $signed({1'b0, one_minus_k});
      mul_b = $signed({2'b0, p1_r});
    end else begin
      mul_a = $signed({1'b0, k_r});
      mul_b = $signed({diff[EstW], diff});
    end
    prod_nxt = mul_a * mul_b;

    // round to nearest, ties toward +inf
    prod_rnd = prod_r + 52'sd32768;
    x_nxt    = {{2{x_r[EstW-1]}}, x_r} + prod_rnd[49:16];
    sat      = (x_nxt[33:31] != 3'b000) && (x_nxt[33:31] != 3'b111);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r        <= RST_PROCESS_NOISE;
      r_r        <= RST_MEASUREMENT_NOISE;
      init_est_r <= RST_INITIAL_ESTIMATE;
      init_cov_r <= RST_INITIAL_COVARIANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE:      q_r        <= cfg_wdata[CovW-1:0];
        REG_MEASUREMENT_NOISE:  r_r        <= cfg_wdata[CovW-1:0];
        REG_INITIAL_ESTIMATE:   init_est_r <= cfg_wdata;
        REG_INITIAL_COVARIANCE: init_cov_r <= cfg_wdata[CovW-1:0];
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= RST_INITIAL_ESTIMATE;
      p_r      <= {1'b0, RST_INITIAL_COVARIANCE};
      halted_r <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      if (cmd.accept && in_restart) begin
        x_r      <= init_est_r;
        p_r      <= {1'b0, init_cov_r};
        halted_r <= 1'b0;
      end
      if (cmd.check) begin
        err_r <= bad;
        if (bad) halted_r <= 1'b1;
      end
      if (cmd.upd_x) begin
        err_r <= sat;
        if (sat) begin
          halted_r <= 1'b1;
        end else begin
          x_r <= x_nxt[EstW-1:0];
        end
      end
      if (cmd.upd_p) p_r <= prod_r[47:16];
    end
  end

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) z_r <= in_measurement;
    if (cmd.check) begin
      p1_r  <= p1_nxt;
      den_r <= den_nxt[EstW-1:0];
      rem_r <= {1'b0, p1_nxt};
      k_r   <= '0;
      cnt_r <= DIV_LAST_BIT;
    end
    if (cmd.div_step) begin
      k_r   <= {k_r[GainW-2:0], rem_ge};
      rem_r <= {rem_diff[EstW-1:0], 1'b0};
      cnt_r <= cnt_r - 5'd1;
    end
    if (cmd.mul_x || cmd.mul_p) prod_r <= prod_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_est_r  <= x_r;
      out_gain_r <= err_r ? '0 : k_r;
      out_err_r  <= err_r;
    end
  end

  assign status.bad      = bad;
  assign status.sat      = sat;
  assign status.div_done = (cnt_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_gain     = out_gain_r;
  assign out_error    = out_err_r;

endmodule

// ===== hdl/scalar_kalman_filter.sv =====
// one request at a time: an accepted request passes through check, the bit-serial divide
// for the gain, two multiply/update pairs and the result load; a request that errors out
// at check or at the estimate update, or finds the filter halted, goes straight to the result load
// no new request is taken until the current result has been loaded into the output register
// rst_n is synchronous: settings and filter state return to reset values, estimate 0, covariance 1.0,
// halt cleared, no result pending
module scalar_kalman_filter import skf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CfgW-1:0]         cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [EstW-1:0]  in_measurement,
  input  logic                    in_restart,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [EstW-1:0]  out_estimate,
  output logic [GainW-1:0]        out_gain,
  output logic                    out_error
);

  skf_cmd_t    cmd;
  skf_status_t status;

  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  skf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_measurement (in_measurement),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_estimate   (out_estimate),
    .out_gain       (out_gain),
    .out_error      (out_error),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

// ===== dv/scalar_kalman_filter_checker.sv =====
module scalar_kalman_filter_checker import skf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgW-1:0]        cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic signed [EstW-1:0] in_measurement,
  input  logic                   in_restart,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic signed [EstW-1:0] out_estimate,
  input  logic [GainW-1:0]       out_gain,
  input  logic                   out_error,
  output int                     mismatch_count,
  output int                     results_pending
);

  typedef struct packed {
    logic signed [EstW-1:0] estimate;
    logic [GainW-1:0]       gain;
    logic                   error;
  } filter_result_t;

  // shadow copy of the settings
  logic [CovW-1:0]        q_noise;
  logic [CovW-1:0]        r_noise;
  logic signed [EstW-1:0] x_start;
  logic [CovW-1:0]        p_start;

  // shadow copy of the filter state
  logic signed [EstW-1:0] x_state;
  logic [CovW-1:0]        p_state;
  logic                   halted;

  filter_result_t expected_estimates[$];
  int results_seen;

  function automatic filter_result_t kalman_update(logic signed [EstW-1:0] z, logic restart);
    filter_result_t    res;
    longint unsigned   p1;
    longint unsigned   den;
    longint unsigned   k;
    longint unsigned   pn;
    longint            innovation;
    longint            product;
    longint            x_new;
    if (restart) begin
      x_state = x_start;
      p_state = p_start;
      halted  = 1'b0;
    end
    res.estimate = x_state;
    res.gain     = '0;
    res.error    = 1'b1;
    if (halted) return res;

    p1  = 64'(p_state) + 64'(q_noise);
    den = p1 + 64'(r_noise);
    // covariance overflow or zero denominator both halt the filter
    if (p1 > 64'h7FFF_FFFF || den == 0) begin
      halted = 1'b1;
      return res;
    end

    k          = (p1 << 16) / den;
    innovation = longint'(z) - longint'(x_state);
    product    = longint'(k) * innovation;
    // round half up
    x_new      = longint'(x_state) + ((product + 64'sd32768) >>> 16);
    if (x_new > 64'sd2147483647 || x_new < -64'sd2147483648) begin
      halted = 1'b1;
      return res;
    end
    pn = ((64'(GAIN_ONE) - k) * p1) >> 16;

    x_state      = x_new[EstW-1:0];
    p_state      = pn[CovW-1:0];
    res.estimate = x_new[EstW-1:0];
    res.gain     = k[GainW-1:0];
    res.error    = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("result %0d: %s expected %0h got %0h", results_seen, what, want, got);
  endtask

  always @(posedge clk) begin : monitor
    filter_result_t want;
    if (!rst_n) begin
      q_noise = RST_PROCESS_NOISE;
      r_noise = RST_MEASUREMENT_NOISE;
      x_start = RST_INITIAL_ESTIMATE;
      p_start = RST_INITIAL_COVARIANCE;
      x_state = RST_INITIAL_ESTIMATE;
      p_state = RST_INITIAL_COVARIANCE;
      halted  = 1'b0;
      mismatch_count = 0;
      results_seen   = 0;
      expected_estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROCESS_NOISE:      q_noise = cfg_wdata[CovW-1:0];
          REG_MEASUREMENT_NOISE:  r_noise = cfg_wdata[CovW-1:0];
          REG_INITIAL_ESTIMATE:   x_start = cfg_wdata[EstW-1:0];
          REG_INITIAL_COVARIANCE: p_start = cfg_wdata[CovW-1:0];
          default: ;
        endcase
      end
      // results first so a request taken on the same edge queues behind them
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_estimates.size() == 0) begin
          report_mismatch("unexpected result, estimate", '0, out_estimate);
        end else begin
          want = expected_estimates.pop_front();
          if (out_estimate !== want.estimate)
            report_mismatch("estimate", want.estimate, out_estimate);
          if (out_gain !== want.gain)
            report_mismatch("gain", want.gain, out_gain);
          if (out_error !== want.error)
            report_mismatch("error", want.error, out_error);
        end
      end
      if (in_valid && !in_stall)
        expected_estimates.push_back(kalman_update(in_measurement, in_restart));
    end
    results_pending = expected_estimates.size();
  end

endmodule

// ===== dv/scalar_kalman_filter_test.sv =====
module scalar_kalman_filter_test;
  import skf_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 400;
  localparam int HoldOffAt     = 100;
  localparam int Phases        = 7;
  localparam int PhaseRequests = 250;
  localparam int SettleCycles  = 40;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CfgIdxW-1:0]     cfg_index;
  logic [CfgW-1:0]        cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [EstW-1:0] in_measurement;
  logic                   in_restart;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [EstW-1:0] out_estimate;
  logic [GainW-1:0]       out_gain;
  logic                   out_error;

  int mismatch_count;
  int results_pending;
  int results_taken = 0;
  int idle_cycles = 0;
  bit steady_flow = 1'b0;

  scalar_kalman_filter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_measurement (in_measurement),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_estimate   (out_estimate),
    .out_gain       (out_gain),
    .out_error      (out_error)
  );

  scalar_kalman_filter_checker kalman_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_measurement  (in_measurement),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_estimate    (out_estimate),
    .out_gain        (out_gain),
    .out_error       (out_error),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("** scalar_kalman_filter: FAILED **");
      $finish;
    end
  end

  task automatic send_request(input logic signed [EstW-1:0] z, input logic restart);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_measurement <= z;
    in_restart     <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  // settings only change while nothing is in flight
  task automatic program_filter(input logic [CfgW-1:0] q, input logic [CfgW-1:0] r,
                                input logic [CfgW-1:0] x0, input logic [CfgW-1:0] p0);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PROCESS_NOISE;
    cfg_wdata <= q;
    @(negedge clk);
    cfg_index <= REG_MEASUREMENT_NOISE;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_index <= REG_INITIAL_ESTIMATE;
    cfg_wdata <= x0;
    @(negedge clk);
    cfg_index <= REG_INITIAL_COVARIANCE;
    cfg_wdata <= p0;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] pick_noise();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      3:       return $urandom_range(1, 255);
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [EstW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 15);
      // one long hold-off so the filter backs up into its input
      if (results_taken == HoldOffAt) hold = HoldOffCycles;
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_taken++;
    end
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_PROCESS_NOISE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_measurement = '0;
    in_restart     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, full-scale swings
    send_request(32'sh7FFF_FFFF, 1'b0);
    send_request(32'sh8000_0000, 1'b0);
    send_request(32'sh0000_0000, 1'b0);
    send_request(-32'sd1, 1'b0);
    send_request(32'sh7FFF_FFFF, 1'b1);
    send_request(32'sh8000_0000, 1'b0);

    // all noise zero: zero denominator, then halted requests
    program_filter(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0);
    send_request(32'sh8000_0000, 1'b1);
    send_request(32'sh0000_0000, 1'b0);
    send_request(32'sd12345, 1'b0);
    // unity gain from a tiny covariance, then covariance collapses to zero
    program_filter(32'h0, 32'h0, 32'h8000_0000, 32'h1);
    send_request(32'sh7FFF_FFFF, 1'b1);
    send_request(32'sh0000_0000, 1'b0);

    // maximum noise: covariance overflow, halt, then restart recovers
    program_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_request(32'sd1, 1'b1);
    send_request(-32'sd1, 1'b0);
    send_request(32'sh0000_0000, 1'b0);
    send_request(32'sh7FFF_FFFF, 1'b1);

    for (int phase = 0; phase < Phases; phase++) begin
      program_filter(pick_noise(), pick_noise(), pick_value(), pick_noise());
      steady_flow = (phase % 3 == 1);
      for (int n = 0; n < PhaseRequests; n++)
        send_request(pick_value(), n == 0 || $urandom_range(0, 15) == 0);
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0)
      $display("** scalar_kalman_filter: PASSED **");
    else
      $display("** scalar_kalman_filter: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/skf_pkg.sv
hdl/skf_ctrl.sv
hdl/skf_dp.sv
hdl/scalar_kalman_filter.sv
dv/scalar_kalman_filter_checker.sv
dv/scalar_kalman_filter_test.sv
